### hdl/track_line_residual_sum_top_macros.svh
// assertion macros shared by the track line residual sum rtl
`ifndef TRACK_LINE_RESIDUAL_SUM_TOP_MACROS_SVH
`define TRACK_LINE_RESIDUAL_SUM_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define TLRS_CHECK_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TLRS_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tlrs_pkg.sv
// types, constants and micro-op table for the track line residual sum block
`default_nettype none

package tlrs_pkg;

    // field and datapath widths
    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int RES_W         = 48;
    localparam int SUM_W         = 56;
    localparam int OPD_W         = COORD_W + 1;
    localparam int PROD_W        = 2 * OPD_W;
    localparam int E_W           = 2 * COORD_W + 1;
    localparam int DEN_W         = 2 * COORD_W;
    localparam int NUM_W         = 2 * E_W;
    localparam int CFG_IDX_W     = 2;
    localparam int IN_TDATA_W    = 3 * COORD_W;
    localparam int IN_TUSER_W    = 3;
    localparam int OUT_TDATA_W   = RES_W + SUM_W;
    localparam int OUT_TUSER_W   = 1;
    localparam int NUM_UOPS      = 18;
    localparam int UOP_IDX_W     = $clog2(NUM_UOPS + 1);
    localparam int DIV_CNT_W     = $clog2(RES_W);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_OFFSET = 2'd0,
        REG_X_SLOPE  = 2'd1,
        REG_Y_OFFSET = 2'd2,
        REG_Y_SLOPE  = 2'd3
    } t_reg_idx;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DCHK,
        S_DIV,
        S_SUM
    } t_state;

    // multiplier operand sources
    typedef enum logic [3:0] {
        OPD_VX,
        OPD_VY,
        OPD_AX,
        OPD_AY,
        OPD_HZ,
        OPD_ONE,
        OPD_EXH,
        OPD_EXL,
        OPD_EYH,
        OPD_EYL,
        OPD_CH,
        OPD_CL
    } t_opnd;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef enum logic [1:0] {
        SH_0,
        SH_33,
        SH_64
    } t_shift;

    typedef enum logic [2:0] {
        STO_NONE,
        STO_EX,
        STO_EY,
        STO_C,
        STO_DEN
    } t_store;

    // which hits an op applies to
    typedef enum logic [1:0] {
        G_ALWAYS,
        G_BOTH,
        G_X,
        G_Y
    } t_gate;

    typedef struct packed {
        t_opnd   a;
        t_opnd   b;
        t_acc_op acc_op;
        t_shift  shift;
        t_store  store;
        t_gate   gate;
    } t_uop;

    // control word from the sequencer to the shared unit
    typedef struct packed {
        t_opnd   mul_a;
        t_opnd   mul_b;
        t_acc_op acc_op;
        t_shift  shift;
        t_store  store;
        logic    div_chk;
        logic    div_step;
    } t_alu_ctrl;

    // micro-op table: residuals, cross term, denominator, then squares
    function automatic t_uop tlrs_uop(input logic [UOP_IDX_W-1:0] idx);
        t_uop u;
        u = '{a: OPD_ONE, b: OPD_ONE, acc_op: ACC_HOLD, shift: SH_0,
              store: STO_NONE, gate: G_ALWAYS};
        unique case (idx)
            5'd0:  begin u.a = OPD_VX;  u.b = OPD_ONE; u.acc_op = ACC_LOAD; end
            5'd1:  begin
                u.a = OPD_AX; u.b = OPD_HZ; u.acc_op = ACC_SUB; u.store = STO_EX;
            end
            5'd2:  begin u.a = OPD_VY;  u.b = OPD_ONE; u.acc_op = ACC_LOAD; end
            5'd3:  begin
                u.a = OPD_AY; u.b = OPD_HZ; u.acc_op = ACC_SUB; u.store = STO_EY;
            end
            5'd4:  begin u.a = OPD_VX;  u.b = OPD_AY;  u.acc_op = ACC_LOAD; end
            5'd5:  begin
                u.a = OPD_VY; u.b = OPD_AX; u.acc_op = ACC_SUB; u.store = STO_C;
            end
            5'd6:  begin u.a = OPD_ONE; u.b = OPD_ONE; u.acc_op = ACC_LOAD; end
            5'd7:  begin
                u.a = OPD_AX; u.b = OPD_AX; u.acc_op = ACC_ADD; u.gate = G_BOTH;
            end
            5'd8:  begin
                u.a = OPD_AY; u.b = OPD_AY; u.acc_op = ACC_ADD; u.gate = G_BOTH;
                u.store = STO_DEN;
            end
            5'd9:  begin
                u.a = OPD_EXH; u.b = OPD_EXH; u.acc_op = ACC_ADD; u.shift = SH_64;
                u.gate = G_X;
            end
            5'd10: begin
                u.a = OPD_EXH; u.b = OPD_EXL; u.acc_op = ACC_ADD; u.shift = SH_33;
                u.gate = G_X;
            end
            5'd11: begin
                u.a = OPD_EXL; u.b = OPD_EXL; u.acc_op = ACC_ADD; u.gate = G_X;
            end
            5'd12: begin
                u.a = OPD_EYH; u.b = OPD_EYH; u.acc_op = ACC_ADD; u.shift = SH_64;
                u.gate = G_Y;
            end
            5'd13: begin
                u.a = OPD_EYH; u.b = OPD_EYL; u.acc_op = ACC_ADD; u.shift = SH_33;
                u.gate = G_Y;
            end
            5'd14: begin
                u.a = OPD_EYL; u.b = OPD_EYL; u.acc_op = ACC_ADD; u.gate = G_Y;
            end
            5'd15: begin
                u.a = OPD_CH; u.b = OPD_CH; u.acc_op = ACC_ADD; u.shift = SH_64;
                u.gate = G_BOTH;
            end
            5'd16: begin
                u.a = OPD_CH; u.b = OPD_CL; u.acc_op = ACC_ADD; u.shift = SH_33;
                u.gate = G_BOTH;
            end
            5'd17: begin
                u.a = OPD_CL; u.b = OPD_CL; u.acc_op = ACC_ADD; u.gate = G_BOTH;
            end
            default: begin
                u.acc_op = ACC_HOLD;
            end
        endcase
        return u;
    endfunction

    // gate of an op against the measured flags of the hit
    function automatic logic tlrs_gate_on(input t_gate g, input logic xm, input logic ym);
        logic on;
        on = 1'b0;
        unique case (g)
            G_ALWAYS: on = 1'b1;
            G_BOTH:   on = xm & ym;
            G_X:      on = xm;
            G_Y:      on = ym;
            default:  on = 1'b0;
        endcase
        return on;
    endfunction

endpackage

`default_nettype wire

### hdl/tlrs_alu.sv
// shared multiply, accumulate and restoring divide unit
`default_nettype none

module tlrs_alu #(
    parameter int FRAC_BITS = tlrs_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  tlrs_pkg::t_alu_ctrl                 i_ctrl,
    input  logic signed [tlrs_pkg::OPD_W-1:0]   i_vx,
    input  logic signed [tlrs_pkg::OPD_W-1:0]   i_vy,
    input  logic signed [tlrs_pkg::COORD_W-1:0] i_ax,
    input  logic signed [tlrs_pkg::COORD_W-1:0] i_ay,
    input  logic signed [tlrs_pkg::COORD_W-1:0] i_hz,
    output logic [tlrs_pkg::RES_W-1:0]          o_q,
    output logic                                o_trial_ge
);
    import tlrs_pkg::*;

    localparam int DSH_W = DEN_W + FRAC_BITS + RES_W;
    localparam int ACC_W = ((DSH_W > NUM_W) ? DSH_W : NUM_W) + 1;
    localparam int LO_W  = COORD_W;

    logic signed [OPD_W-1:0]  w_a;
    logic signed [OPD_W-1:0]  w_b;
    logic signed [OPD_W-1:0]  w_one;
    logic signed [PROD_W-1:0] r_prod;
    logic [E_W-1:0]           r_ex;
    logic [E_W-1:0]           r_ey;
    logic [E_W-1:0]           r_c;
    logic [ACC_W-1:0]         r_acc;
    logic [DSH_W-1:0]         r_dsh;
    logic [RES_W-1:0]         r_q;
    logic [ACC_W-1:0]         w_pext;
    logic [ACC_W-1:0]         w_opnd;
    logic [ACC_W-1:0]         w_base;
    logic [ACC_W-1:0]         w_sum;
    logic [ACC_W-1:0]         w_new;
    logic                     w_div;
    logic                     w_sub;

    assign w_one = OPD_W'(1) << FRAC_BITS;

    // operand select for the shared multiplier
    function automatic logic signed [OPD_W-1:0] opnd_mux(input t_opnd sel);
        logic signed [OPD_W-1:0] v;
        v = '0;
        unique case (sel)
            OPD_VX:  v = i_vx;
            OPD_VY:  v = i_vy;
            OPD_AX:  v = {i_ax[COORD_W-1], i_ax};
            OPD_AY:  v = {i_ay[COORD_W-1], i_ay};
            OPD_HZ:  v = {i_hz[COORD_W-1], i_hz};
            OPD_ONE: v = w_one;
            OPD_EXH: v = r_ex[E_W-1:LO_W];
            OPD_EXL: v = {1'b0, r_ex[LO_W-1:0]};
            OPD_EYH: v = r_ey[E_W-1:LO_W];
            OPD_EYL: v = {1'b0, r_ey[LO_W-1:0]};
            OPD_CH:  v = r_c[E_W-1:LO_W];
            OPD_CL:  v = {1'b0, r_c[LO_W-1:0]};
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        w_a = opnd_mux(i_ctrl.mul_a);
        w_b = opnd_mux(i_ctrl.mul_b);
    end

    // product placed at its weight
    always_comb begin
        w_pext = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        unique case (i_ctrl.shift)
            SH_0:    w_opnd = w_pext;
            SH_33:   w_opnd = w_pext << (LO_W + 1);
            SH_64:   w_opnd = w_pext << (2 * LO_W);
            default: w_opnd = w_pext;
        endcase
        if (w_div) begin
            w_opnd = {{(ACC_W - DSH_W){1'b0}}, r_dsh};
        end
    end

    // the one wide adder: accumulate or trial subtract
    assign w_div  = i_ctrl.div_chk | i_ctrl.div_step;
    assign w_sub  = w_div | (i_ctrl.acc_op == ACC_SUB);
    assign w_base = (!w_div && (i_ctrl.acc_op == ACC_LOAD)) ? '0 : r_acc;
    assign w_sum  = w_base + (w_sub ? ~w_opnd : w_opnd) + ACC_W'(w_sub);
    assign w_new  = (i_ctrl.acc_op == ACC_HOLD) ? r_acc : w_sum;

    assign o_trial_ge = ~w_sum[ACC_W-1];
    assign o_q        = r_q;

    // product register
    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
    end

    // accumulator, stored terms, divisor and quotient
    always_ff @(posedge i_clk) begin
        if (i_ctrl.div_step) begin
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[RES_W-2:0], o_trial_ge};
            if (o_trial_ge) begin
                r_acc <= w_sum;
            end
        end else if (i_ctrl.div_chk) begin
            r_dsh <= r_dsh >> 1;
            r_q   <= '0;
        end else begin
            r_acc <= w_new;
            unique case (i_ctrl.store)
                STO_NONE: ;
                STO_EX:   r_ex <= w_new[E_W-1:0];
                STO_EY:   r_ey <= w_new[E_W-1:0];
                STO_C:    r_c  <= w_new[E_W-1:0];
                STO_DEN: begin
                    r_dsh <= DSH_W'(w_new[DEN_W-1:0]) << (FRAC_BITS + RES_W);
                    r_acc <= '0;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/track_line_residual_sum_top.sv
// one hit in flight: a measured hit runs the micro-ops, the saturation check and the divide; an unmeasured hit
//   skips check and divide, and a saturating residual skips the divide; the next hit is accepted once idle again
// work per hit: 18 micro-ops on the shared 33x33 multiplier
//   plus one saturation check and 48 restoring divide steps on the shared wide adder
// reset: synchronous active-low; clears line registers, running sum, sticky flag and control
`default_nettype none
`include "track_line_residual_sum_top_macros.svh"

module track_line_residual_sum_top #(
    parameter int FRAC_BITS = tlrs_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [tlrs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tlrs_pkg::COORD_W-1:0]        i_cfg_data,
    // hit stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tlrs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // hit_x, hit_y, hit_z
    input  logic [tlrs_pkg::IN_TUSER_W-1:0]     s_axis_tuser,  // first_of_track, x_measured, y_measured
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tlrs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // residual_sq, track_sum
    output logic [tlrs_pkg::OUT_TUSER_W-1:0]    m_axis_tuser   // saturated
);
    import tlrs_pkg::*;

    t_state                    r_state;
    t_state                    n_state;
    logic [UOP_IDX_W-1:0]      r_cnt;
    logic [DIV_CNT_W-1:0]      r_dcnt;
    logic [COORD_W-1:0]        r_x0;
    logic [COORD_W-1:0]        r_ax;
    logic [COORD_W-1:0]        r_y0;
    logic [COORD_W-1:0]        r_ay;
    logic signed [OPD_W-1:0]   r_vx;
    logic signed [OPD_W-1:0]   r_vy;
    logic [COORD_W-1:0]        r_hz;
    logic                      r_first;
    logic                      r_xm;
    logic                      r_ym;
    logic                      r_rsat;
    logic [SUM_W-1:0]          r_total;
    logic                      r_tsat;
    logic                      r_out_valid;
    logic [RES_W-1:0]          r_res;
    logic [SUM_W-1:0]          r_sum;
    logic                      r_sat;
    t_alu_ctrl                 w_ctrl;
    t_uop                      w_mul_uop;
    t_uop                      w_acc_uop;
    logic [RES_W-1:0]          w_q;
    logic                      w_trial_ge;
    logic                      w_accept;
    logic                      w_slot_free;
    logic                      w_load_out;
    logic [COORD_W-1:0]        w_hx;
    logic [COORD_W-1:0]        w_hy;
    logic [RES_W-1:0]          n_res;
    logic [SUM_W:0]            w_tot;
    logic [SUM_W-1:0]          n_total;
    logic                      n_tsat;

    assign w_hx = s_axis_tdata[COORD_W-1:0];
    assign w_hy = s_axis_tdata[2*COORD_W-1:COORD_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign w_load_out    = (r_state == S_SUM) && w_slot_free;

    // line registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x0 <= '0;
            r_ax <= '0;
            r_y0 <= '0;
            r_ay <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_X_OFFSET: r_x0 <= i_cfg_data;
                REG_X_SLOPE:  r_ax <= i_cfg_data;
                REG_Y_OFFSET: r_y0 <= i_cfg_data;
                REG_Y_SLOPE:  r_ay <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // hit capture, offsets removed on the way in
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vx    <= $signed({w_hx[COORD_W-1], w_hx}) - $signed({r_x0[COORD_W-1], r_x0});
            r_vy    <= $signed({w_hy[COORD_W-1], w_hy}) - $signed({r_y0[COORD_W-1], r_y0});
            r_hz    <= s_axis_tdata[3*COORD_W-1:2*COORD_W];
            r_first <= s_axis_tuser[0];
            r_xm    <= s_axis_tuser[1];
            r_ym    <= s_axis_tuser[2];
        end
    end

    // micro-op fetch: multiply for op r_cnt, accumulate for the op before
    assign w_mul_uop = tlrs_uop(r_cnt);
    assign w_acc_uop = tlrs_uop(r_cnt - UOP_IDX_W'(1));

    // next state and control word for the shared unit
    always_comb begin
        n_state         = r_state;
        w_ctrl.mul_a    = w_mul_uop.a;
        w_ctrl.mul_b    = w_mul_uop.b;
        w_ctrl.acc_op   = ACC_HOLD;
        w_ctrl.shift    = w_acc_uop.shift;
        w_ctrl.store    = STO_NONE;
        w_ctrl.div_chk  = 1'b0;
        w_ctrl.div_step = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                w_ctrl.acc_op = tlrs_gate_on(w_acc_uop.gate, r_xm, r_ym) ?
                                w_acc_uop.acc_op : ACC_HOLD;
                w_ctrl.store  = w_acc_uop.store;
                if (r_cnt == UOP_IDX_W'(NUM_UOPS)) begin
                    n_state = (r_xm || r_ym) ? S_DCHK : S_SUM;
                end
            end
            S_DCHK: begin
                w_ctrl.div_chk = 1'b1;
                n_state        = w_trial_ge ? S_SUM : S_DIV;
            end
            S_DIV: begin
                w_ctrl.div_step = 1'b1;
                if (r_dcnt == DIV_CNT_W'(RES_W - 1)) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_dcnt  <= '0;
            r_rsat  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt  <= '0;
                r_rsat <= 1'b0;
            end else if (r_state == S_RUN) begin
                r_cnt <= r_cnt + UOP_IDX_W'(1);
            end
            if (r_state == S_DCHK) begin
                r_dcnt <= '0;
                r_rsat <= w_trial_ge;
            end else if (r_state == S_DIV) begin
                r_dcnt <= r_dcnt + DIV_CNT_W'(1);
            end
        end
    end

    // shared arithmetic unit
    tlrs_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl),
        .i_vx       (r_vx),
        .i_vy       (r_vy),
        .i_ax       (r_ax),
        .i_ay       (r_ay),
        .i_hz       (r_hz),
        .o_q        (w_q),
        .o_trial_ge (w_trial_ge)
    );

    // residual and running sum with saturation
    always_comb begin
        if (r_rsat) begin
            n_res = '1;
        end else if (r_xm || r_ym) begin
            n_res = w_q;
        end else begin
            n_res = '0;
        end
        w_tot = {1'b0, (r_first ? {SUM_W{1'b0}} : r_total)} + (SUM_W + 1)'(n_res);
        n_total = w_tot[SUM_W] ? {SUM_W{1'b1}} : w_tot[SUM_W-1:0];
        n_tsat  = (!r_first && r_tsat) || w_tot[SUM_W] || r_rsat;
    end

    // track state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_tsat  <= 1'b0;
        end else if (w_load_out) begin
            r_total <= n_total;
            r_tsat  <= n_tsat;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_res <= n_res;
            r_sum <= n_total;
            r_sat <= n_tsat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_sum, r_res};
    assign m_axis_tuser  = r_sat;

    // checks
    `TLRS_CHECK_NEXT(a_accept_starts_run, i_clk, i_rst_n, w_accept, (r_state == S_RUN) && (r_cnt == '0), "accepted hit did not start the micro-op run")
    `TLRS_CHECK_NOW(a_div_needs_measure, i_clk, i_rst_n, r_state == S_DIV, (r_xm || r_ym) && !r_rsat, "divide running for unmeasured or saturated hit")
    `TLRS_CHECK_NOW(a_result_from_sum, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_SUM, "result appeared without a sum step")
    `TLRS_CHECK_NOW(a_run_count_bound, i_clk, i_rst_n, r_state == S_RUN, r_cnt <= UOP_IDX_W'(NUM_UOPS), "micro-op counter ran past the table")

endmodule

`default_nettype wire
